### rtl/evc_pkg.sv
// Shared types and constants for the exclusive zone valve controller.
`timescale 1ns / 1ps

package evc_pkg;

	// action codes carried on the input tuser
	typedef enum logic [2:0] {
		ACT_TICK      = 3'd0,
		ACT_OPEN      = 3'd1,
		ACT_CLOSE     = 3'd2,
		ACT_CLOSE_ALL = 3'd3,
		ACT_LOCK      = 3'd4,
		ACT_QUERY     = 3'd5
	} action_t;

	localparam int unsigned ZONE_W    = 4;
	localparam int unsigned DUR_W     = 32;
	localparam int unsigned LEVELS_W  = 8;
	localparam int unsigned IN_DATA_W = 40;
	localparam int unsigned OUT_DATA_W = 16;

	// one input item
	typedef struct packed {
		action_t             action;
		logic [ZONE_W-1:0]   zone;
		logic [DUR_W-1:0]    duration_ms;
	} item_t;

	// one result item
	typedef struct packed {
		logic                accepted;
		logic [ZONE_W-1:0]   open_zone;
		logic                zone_is_open;
		logic [LEVELS_W-1:0] relay_levels;
	} result_t;

endpackage

### rtl/evc_core.sv
// Valve state registers and the single-pass step logic.
`timescale 1ns / 1ps

module evc_core #(
	parameter int unsigned ZONES = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  evc_pkg::item_t   item,
	input  logic             relay_pol_low,
	output evc_pkg::result_t result
);

	logic [evc_pkg::ZONE_W-1:0] active_q, active_d;
	logic [evc_pkg::DUR_W-1:0]  now_q, now_d;
	logic [evc_pkg::DUR_W-1:0]  opened_q, opened_d;
	logic [evc_pkg::DUR_W-1:0]  limit_q, limit_d;
	logic [evc_pkg::DUR_W-1:0]  lockout_q, lockout_d;

	logic                       zone_ok;
	logic                       lock_active;
	logic                       expire;
	logic                       accepted;
	logic [evc_pkg::DUR_W-1:0]  now_inc;
	logic [evc_pkg::DUR_W-1:0]  elapsed;
	logic [evc_pkg::DUR_W-1:0]  lock_diff;
	logic [evc_pkg::LEVELS_W-1:0] levels;

	// shared terms
	assign zone_ok     = (item.zone != '0) && (item.zone <= evc_pkg::ZONE_W'(ZONES));
	assign lock_diff   = now_q - lockout_q;
	assign lock_active = (lockout_q != '0) && lock_diff[evc_pkg::DUR_W-1];
	assign now_inc     = now_q + evc_pkg::DUR_W'(1);
	assign elapsed     = now_inc - opened_q;
	assign expire      = (active_q != '0) && (limit_q != '0) && (elapsed >= limit_q);

	// next state and accepted flag
	always_comb begin
		active_d  = active_q;
		now_d     = now_q;
		opened_d  = opened_q;
		limit_d   = limit_q;
		lockout_d = lockout_q;
		accepted  = 1'b0;
		unique case (item.action)
			evc_pkg::ACT_TICK: begin
				now_d    = now_inc;
				accepted = 1'b1;
				if (expire) begin
					active_d = '0;
					opened_d = '0;
					limit_d  = '0;
				end
			end
			evc_pkg::ACT_OPEN: begin
				priority if (!zone_ok) begin
					accepted = 1'b0;
				end else if (active_q == item.zone) begin
					accepted = 1'b1;
				end else if (lock_active || active_q != '0) begin
					accepted = 1'b0;
				end else begin
					active_d = item.zone;
					opened_d = now_q;
					limit_d  = item.duration_ms;
					accepted = 1'b1;
				end
			end
			evc_pkg::ACT_CLOSE: begin
				if (zone_ok) begin
					accepted = 1'b1;
					if (active_q == item.zone) begin
						active_d = '0;
						opened_d = '0;
						limit_d  = '0;
					end
				end
			end
			evc_pkg::ACT_CLOSE_ALL: begin
				active_d = '0;
				opened_d = '0;
				limit_d  = '0;
				accepted = 1'b1;
			end
			evc_pkg::ACT_LOCK: begin
				lockout_d = now_q + item.duration_ms;
				accepted  = 1'b1;
			end
			evc_pkg::ACT_QUERY: begin
				accepted = zone_ok;
			end
			default: begin
				accepted = 1'b0;
			end
		endcase
	end

	// relay pin levels from the zone open after the step
	always_comb begin
		levels = '0;
		for (int i = 0; i < evc_pkg::LEVELS_W; i++) begin
			if (i < ZONES) begin
				levels[i] = (active_d == evc_pkg::ZONE_W'(i + 1)) ^ relay_pol_low;
			end
		end
	end

	assign result.accepted     = accepted;
	assign result.open_zone    = active_d;
	assign result.zone_is_open = zone_ok && (active_d == item.zone);
	assign result.relay_levels = levels;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			now_q     <= '0;
			opened_q  <= '0;
			limit_q   <= '0;
			lockout_q <= '0;
		end else if (step_en) begin
			active_q  <= active_d;
			now_q     <= now_d;
			opened_q  <= opened_d;
			limit_q   <= limit_d;
			lockout_q <= lockout_d;
		end
	end

	// open zone is never out of range
	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= evc_pkg::ZONE_W'(ZONES))
		else $error("open zone out of range");

	// close all leaves no zone open
	a_close_all: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.action == evc_pkg::ACT_CLOSE_ALL |=> active_q == '0)
		else $error("zone still open after close all");

	// a closed valve carries no timer
	a_closed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == '0 |-> limit_q == '0 && opened_q == '0)
		else $error("timer left set with no zone open");

	// the clock only moves on ticks
	a_now_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.action != evc_pkg::ACT_TICK |=> $stable(now_q))
		else $error("millisecond counter moved without a tick");

endmodule

### rtl/evc_obuf.sv
// Result register between the step logic and the output stream.
`timescale 1ns / 1ps

module evc_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  evc_pkg::result_t in_result,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [evc_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic             valid_q;
	evc_pkg::result_t result_q;

	// free when empty or being drained this cycle
	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q <= in_result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, result_q.relay_levels, result_q.zone_is_open,
		result_q.open_zone, result_q.accepted};

endmodule

### rtl/exclusive_zone_valve_controller.sv
// Top level of the exclusive zone valve controller.
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   tuser: action; tdata: zone, duration_ms
//  m_*       out  m_tvalid / m_tready   tdata: accepted, open_zone, zone_is_open,
//                                        relay_levels
//  cfg_*     in   cfg_valid / cfg_ready cfg_data: relay_pol_low
//
// One item per cycle sustained while m_tready is high; a result reaches m_tdata
// through the input register, then the result register.
// The step logic is one pass of compares and 32-bit adds between those registers.
// Reset clears all timers and closes every zone; relay_pol_low resets to 1.
// A stalled output holds its result while the input register still takes one
// more item; cfg_ready is always high.
`timescale 1ns / 1ps

module exclusive_zone_valve_controller #(
	parameter int unsigned ZONES = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [3:0] zone, [35:4] duration_ms, [39:36] zero
	input  logic [evc_pkg::IN_DATA_W-1:0]    s_tdata,
	// [2:0] action
	input  logic [2:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] accepted, [4:1] open_zone, [5] zone_is_open, [13:6] relay_levels,
	// [15:14] zero
	output logic [evc_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);

	logic             relay_pol_low_q;
	logic             valid_s1;
	evc_pkg::item_t   item_s1;
	logic             advance;
	logic             step_en;
	evc_pkg::result_t result;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_pol_low_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			relay_pol_low_q <= cfg_data;
		end
	end

	// input register
	assign s_tready = !valid_s1 || advance;
	assign step_en  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action      <= evc_pkg::action_t'(s_tuser);
			item_s1.zone        <= s_tdata[evc_pkg::ZONE_W-1:0];
			item_s1.duration_ms <= s_tdata[evc_pkg::ZONE_W +: evc_pkg::DUR_W];
		end
	end

	evc_core #(
		.ZONES(ZONES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.item         (item_s1),
		.relay_pol_low(relay_pol_low_q),
		.result       (result)
	);

	evc_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (step_en),
		.in_ready (advance),
		.in_result(result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
